// ----- hdl/pcm_downmix_resample_requantize_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the PCM downmix / resample / requantise block
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PCM_DOWNMIX_RESAMPLE_REQUANTIZE_ASSERT_SVH
`define PCM_DOWNMIX_RESAMPLE_REQUANTIZE_ASSERT_SVH

`ifndef SYNTH
// Implication checked on every rising clock edge outside reset
`define PDR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcm_downmix_resample_requantize: assertion failed");
// Condition that must never hold outside reset
`define PDR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `PDR_ASSERT_IMPL(lbl, clk, rst_n, 1'b1, !(expr))
`else
`define PDR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PDR_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- hdl/pcmdr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmdr_pkg
// Types and constants shared by the PCM downmix / resample / requantise block.
// ----------------------------------------------------------------------------
package pcmdr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RATE_W     = 16;
    localparam int POS_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 2 * RATE_W;
    localparam int BYTE_W     = 8;
    localparam int DIV_CNT_W  = 5;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;

    localparam logic [RATE_W-1:0]    RATE_RESET      = 16'd44100;
    localparam logic [POS_W-1:0]     FRAME_LEN_RESET = 11'd1152;
    localparam logic [BYTE_W-1:0]    BYTE_BIAS       = 8'd128;
    localparam logic [DIV_CNT_W-1:0] QUO_LONG        = DIV_CNT_W'(RATE_W);
    localparam logic [DIV_CNT_W-1:0] QUO_SHORT       = DIV_CNT_W'(POS_W);
    localparam int                   QUO_ALIGN       = RATE_W - POS_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_RATE   = 3'd0,
        CFG_OUTPUT_RATE   = 3'd1,
        CFG_MONO_OUT      = 3'd2,
        CFG_EIGHT_BIT_OUT = 3'd3,
        CFG_FRAME_LENGTH  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [RATE_W-1:0] source_rate;
        logic [RATE_W-1:0] output_rate;
        logic              mono_out;
        logic              eight_bit_out;
        logic [POS_W-1:0]  frame_length;   // already clamped to 1..max
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       stereo_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_value;
        logic signed [SAMPLE_W-1:0] second_value;
        logic                       two_channels;
        logic                       last_of_run;
    } t_out;

    // One classified request handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a_left;
        logic signed [SAMPLE_W-1:0] a_right;
        logic signed [SAMPLE_W-1:0] b_left;
        logic signed [SAMPLE_W-1:0] b_right;
        logic [POS_W-1:0]           pos;
        logic                       frame_end;
        logic                       two;
    } t_qent;

    typedef struct packed {
        logic              start;
        logic              short_q;
        logic [PROD_W-1:0] num;
        logic [RATE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [RATE_W-1:0] quo;
        logic [RATE_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_BYPASS,
        BK_OUTS_MUL,
        BK_OUTS_WAIT,
        BK_CHECK,
        BK_IDX_WAIT,
        BK_DECIDE,
        BK_L_WAIT,
        BK_R_WAIT,
        BK_STORE,
        BK_FLUSH
    } t_bk_state;

endpackage

// ----- hdl/pcmdr_front.sv -----
// ----------------------------------------------------------------------------
// pcmdr_front
// Accepts sample pairs, downmixes, tracks the frame position and queues work.
// ----------------------------------------------------------------------------
module pcmdr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcmdr_pkg::t_cfg   i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pcmdr_pkg::t_in    i_in_data,
    output logic              o_push,
    output pcmdr_pkg::t_qent  o_push_data,
    input  logic              i_q_full
);
    import pcmdr_pkg::*;

    logic signed [SAMPLE_W-1:0] r_held_l, n_held_l, r_held_r, n_held_r;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic [SAMPLE_W:0]          mix_sum, mix_adj;
    logic signed [SAMPLE_W-1:0] proc_l, proc_r;
    logic                       two, frame_end, accept;

    always_comb begin
        // Average toward zero: bias negative sums by one before halving
        mix_sum = {i_in_data.left_sample[SAMPLE_W-1], i_in_data.left_sample}
                + {i_in_data.right_sample[SAMPLE_W-1], i_in_data.right_sample};
        mix_adj = mix_sum + {{SAMPLE_W{1'b0}}, mix_sum[SAMPLE_W]};

        two    = i_in_data.stereo_in & ~i_cfg.mono_out;
        proc_l = (i_in_data.stereo_in && i_cfg.mono_out) ? mix_adj[SAMPLE_W:1]
                                                         : i_in_data.left_sample;
        proc_r = two ? i_in_data.right_sample : '0;

        frame_end = ({1'b0, r_pos} + (POS_W+1)'(1)) >= {1'b0, i_cfg.frame_length};

        accept     = i_in_valid & ~i_q_full;
        o_in_ready = ~i_q_full;
        o_push     = accept;

        o_push_data.a_left    = r_held_l;
        o_push_data.a_right   = r_held_r;
        o_push_data.b_left    = proc_l;
        o_push_data.b_right   = proc_r;
        o_push_data.pos       = r_pos;
        o_push_data.frame_end = frame_end;
        o_push_data.two       = two;

        n_held_l = r_held_l;
        n_held_r = r_held_r;
        n_pos    = r_pos;
        if (accept) begin
            n_held_l = proc_l;
            n_held_r = proc_r;
            n_pos    = frame_end ? '0 : r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_l <= '0;
            r_held_r <= '0;
            r_pos    <= '0;
        end else begin
            r_held_l <= n_held_l;
            r_held_r <= n_held_r;
            r_pos    <= n_pos;
        end
    end

endmodule

// ----- hdl/pcmdr_fifo.sv -----
// ----------------------------------------------------------------------------
// pcmdr_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
`include "pcm_downmix_resample_requantize_assert.svh"

module pcmdr_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcmdr_pkg::t_qent  i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output pcmdr_pkg::t_qent  o_pop_data,
    output logic              o_empty
);
    import pcmdr_pkg::*;

    t_qent                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp, r_rp;
    logic [FIFO_PTR_W:0]   r_cnt;

    assign o_full     = (r_cnt == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_data;
    end

    `PDR_ASSERT_NEVER(a_fifo_overflow, i_clk, i_rst_n, i_push && o_full)
    `PDR_ASSERT_NEVER(a_fifo_underflow, i_clk, i_rst_n, i_pop && o_empty)

endmodule

// ----- hdl/pcmdr_div.sv -----
// ----------------------------------------------------------------------------
// pcmdr_div
// Restoring divider, one quotient bit a cycle, 11 or 16 quotient bits.
// ----------------------------------------------------------------------------
module pcmdr_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcmdr_pkg::t_div_req  i_req,
    output pcmdr_pkg::t_div_rsp  o_rsp
);
    import pcmdr_pkg::*;

    logic                 r_busy, n_busy, r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [RATE_W-1:0]    r_rem, n_rem, r_quo, n_quo, r_den, n_den;
    logic [RATE_W:0]      trial, diff;
    logic                 ge;

    always_comb begin
        trial = {r_rem, r_quo[RATE_W-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = ge ? trial - {1'b0, r_den} : trial;

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            // Upper half is already below the divisor
            n_busy = 1'b1;
            n_cnt  = i_req.short_q ? QUO_SHORT : QUO_LONG;
            n_rem  = i_req.num[PROD_W-1:RATE_W];
            n_quo  = i_req.num[RATE_W-1:0];
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = diff[RATE_W-1:0];
            n_quo = {r_quo[RATE_W-2:0], ge};
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- hdl/pcmdr_back.sv -----
// ----------------------------------------------------------------------------
// pcmdr_back
// Resampling sequencer: schedules outputs, interpolates, requantises.
// ----------------------------------------------------------------------------
`include "pcm_downmix_resample_requantize_assert.svh"

module pcmdr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcmdr_pkg::t_cfg      i_cfg,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    input  pcmdr_pkg::t_qent     i_q_data,
    output pcmdr_pkg::t_div_req  o_div_req,
    input  pcmdr_pkg::t_div_rsp  i_div_rsp,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pcmdr_pkg::t_out      o_out_data
);
    import pcmdr_pkg::*;

    t_bk_state                  r_state, n_state;
    t_qent                      r_ent, n_ent;
    logic [POS_W-1:0]           r_outs, n_outs, r_op, n_op, r_idx, n_idx;
    logic [1:0]                 r_k, n_k;
    logic [RATE_W-1:0]          r_frac, n_frac, r_den, n_den;
    logic [PROD_W-1:0]          r_prod, n_prod;
    logic                       r_go, n_go, r_go_short, n_go_short, r_neg, n_neg;
    logic signed [SAMPLE_W-1:0] r_res_l, n_res_l, r_res_r, n_res_r;
    logic                       r_pend_v, n_pend_v, r_out_v, n_out_v;
    t_out                       r_pend, n_pend, r_out, n_out, new_res;
    logic                       resamp, out_free, out_load;
    logic [RATE_W-1:0]          mul_a, mul_b;
    logic [PROD_W-1:0]          mul_p;
    logic [SAMPLE_W:0]          dm_l, dm_r;

    function automatic logic signed [SAMPLE_W-1:0] quantize(
        input logic signed [SAMPLE_W-1:0] s,
        input logic                       eight
    );
        logic [BYTE_W-1:0] hi;
        hi = s[SAMPLE_W-1 -: BYTE_W] + BYTE_BIAS;
        return eight ? SAMPLE_W'(hi) : s;
    endfunction

    // Sign and magnitude of b - a
    function automatic logic [SAMPLE_W:0] diff_mag(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic [SAMPLE_W:0] d, m;
        d = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
        m = d[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - d) : d;
        return {d[SAMPLE_W], m[SAMPLE_W-1:0]};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] interp_add(
        input logic signed [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0]        q,
        input logic                       neg
    );
        logic [SAMPLE_W:0] sq, s;
        sq = neg ? ((SAMPLE_W+1)'(0) - {1'b0, q}) : {1'b0, q};
        s  = {a[SAMPLE_W-1], a} + sq;
        return s[SAMPLE_W-1:0];
    endfunction

    always_comb begin
        resamp   = (i_cfg.output_rate != '0) && (i_cfg.output_rate < i_cfg.source_rate);
        out_free = ~r_out_v | i_out_ready;
        dm_l     = diff_mag(r_ent.a_left, r_ent.b_left);
        dm_r     = diff_mag(r_ent.a_right, r_ent.b_right);

        new_res.first_value  = quantize(r_res_l, i_cfg.eight_bit_out);
        new_res.second_value = r_ent.two ? quantize(r_res_r, i_cfg.eight_bit_out) : '0;
        new_res.two_channels = r_ent.two;
        new_res.last_of_run  = 1'b0;
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state    = r_state;
        n_ent      = r_ent;
        n_outs     = r_outs;
        n_op       = r_op;
        n_idx      = r_idx;
        n_k        = r_k;
        n_frac     = r_frac;
        n_den      = r_den;
        n_prod     = r_prod;
        n_go       = 1'b0;
        n_go_short = r_go_short;
        n_neg      = r_neg;
        n_res_l    = r_res_l;
        n_res_r    = r_res_r;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out      = r_out;
        out_load   = 1'b0;
        o_pop      = 1'b0;
        mul_a      = '0;
        mul_b      = '0;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_ent   = i_q_data;
                    n_k     = '0;
                    n_state = resamp ? BK_OUTS_MUL : BK_BYPASS;
                end
            end
            BK_BYPASS: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    n_out.first_value  = quantize(r_ent.b_left, i_cfg.eight_bit_out);
                    n_out.second_value = r_ent.two ?
                                         quantize(r_ent.b_right, i_cfg.eight_bit_out) : '0;
                    n_out.two_channels = r_ent.two;
                    n_out.last_of_run  = 1'b1;
                    n_state            = BK_IDLE;
                    if (r_ent.frame_end) n_op = '0;
                end
            end
            BK_OUTS_MUL: begin
                // outputs in this frame = n * dst / src
                mul_a      = RATE_W'(i_cfg.frame_length);
                mul_b      = i_cfg.output_rate;
                n_prod     = mul_p;
                n_den      = i_cfg.source_rate;
                n_go       = 1'b1;
                n_go_short = 1'b1;
                n_state    = BK_OUTS_WAIT;
            end
            BK_OUTS_WAIT: begin
                if (i_div_rsp.done) begin
                    n_outs  = i_div_rsp.quo[POS_W-1:0];
                    n_state = BK_CHECK;
                end
            end
            BK_CHECK: begin
                if ((r_k != 2'd2) && (r_op < r_outs)) begin
                    mul_a      = RATE_W'(r_op);
                    mul_b      = i_cfg.source_rate;
                    n_prod     = mul_p;
                    n_den      = i_cfg.output_rate;
                    n_go       = 1'b1;
                    n_go_short = 1'b1;
                    n_state    = BK_IDX_WAIT;
                end else if (r_pend_v) begin
                    n_state = BK_FLUSH;
                end else begin
                    n_state = BK_IDLE;
                    if (r_ent.frame_end) n_op = '0;
                end
            end
            BK_IDX_WAIT: begin
                if (i_div_rsp.done) begin
                    n_idx   = i_div_rsp.quo[POS_W-1:0];
                    n_frac  = i_div_rsp.rem;
                    n_state = BK_DECIDE;
                end
            end
            BK_DECIDE: begin
                if (r_idx < r_ent.pos) begin
                    mul_a      = dm_l[SAMPLE_W-1:0];
                    mul_b      = r_frac;
                    n_prod     = mul_p;
                    n_neg      = dm_l[SAMPLE_W];
                    n_go       = 1'b1;
                    n_go_short = 1'b0;
                    n_state    = BK_L_WAIT;
                end else if ((r_idx == r_ent.pos) && r_ent.frame_end) begin
                    // No next sample: copy the current one
                    n_res_l = r_ent.b_left;
                    n_res_r = r_ent.b_right;
                    n_state = BK_STORE;
                end else if (r_pend_v) begin
                    n_state = BK_FLUSH;
                end else begin
                    n_state = BK_IDLE;
                    if (r_ent.frame_end) n_op = '0;
                end
            end
            BK_L_WAIT: begin
                if (i_div_rsp.done) begin
                    n_res_l = interp_add(r_ent.a_left, i_div_rsp.quo, r_neg);
                    if (r_ent.two) begin
                        mul_a      = dm_r[SAMPLE_W-1:0];
                        mul_b      = r_frac;
                        n_prod     = mul_p;
                        n_neg      = dm_r[SAMPLE_W];
                        n_go       = 1'b1;
                        n_go_short = 1'b0;
                        n_state    = BK_R_WAIT;
                    end else begin
                        n_res_r = '0;
                        n_state = BK_STORE;
                    end
                end
            end
            BK_R_WAIT: begin
                if (i_div_rsp.done) begin
                    n_res_r = interp_add(r_ent.a_right, i_div_rsp.quo, r_neg);
                    n_state = BK_STORE;
                end
            end
            BK_STORE: begin
                // Hold one result back so the last of the run can be marked
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        out_load = 1'b1;
                        n_out    = r_pend;
                    end
                    n_pend   = new_res;
                    n_pend_v = 1'b1;
                    n_k      = r_k + 2'd1;
                    n_op     = r_op + POS_W'(1);
                    n_state  = BK_CHECK;
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out             = r_pend;
                    n_out.last_of_run = 1'b1;
                    n_pend_v          = 1'b0;
                    n_state           = BK_IDLE;
                    if (r_ent.frame_end) n_op = '0;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        n_out_v = out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_op     <= '0;
            r_k      <= '0;
            r_go     <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_k      <= n_k;
            r_go     <= n_go;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent      <= n_ent;
        r_outs     <= n_outs;
        r_idx      <= n_idx;
        r_frac     <= n_frac;
        r_den      <= n_den;
        r_prod     <= n_prod;
        r_go_short <= n_go_short;
        r_neg      <= n_neg;
        r_res_l    <= n_res_l;
        r_res_r    <= n_res_r;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_div_req.start   = r_go;
    assign o_div_req.short_q = r_go_short;
    assign o_div_req.num     = r_go_short ? {r_prod[PROD_W-QUO_ALIGN-1:0], QUO_ALIGN'(0)}
                                          : r_prod;
    assign o_div_req.den     = r_den;
    assign o_out_valid       = r_out_v;
    assign o_out_data        = r_out;

    `PDR_ASSERT_NEVER(a_div_start_busy, i_clk, i_rst_n, r_go && i_div_rsp.busy)
    `PDR_ASSERT_NEVER(a_out_overwrite, i_clk, i_rst_n, out_load && r_out_v && !i_out_ready)
    `PDR_ASSERT_IMPL(a_mono_second_zero, i_clk, i_rst_n, r_out_v && !r_out.two_channels, r_out.second_value == '0)

endmodule

// ----- hdl/pcm_downmix_resample_requantize.sv -----
// ----------------------------------------------------------------------------
// pcm_downmix_resample_requantize
// Stereo downmix, linear-interpolation downsampler and 8/16-bit requantiser.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ---------------------
//  in        sink       i_in_valid / o_in_ready    i_in_data  (t_in)
//  out       source     o_out_valid / i_out_ready  o_out_data (t_out)
//  cfg       sink       i_cfg_we, no back-pressure i_cfg_idx, i_cfg_wdata
//
//  Pass-through (output rate zero or not below source rate): one result a request.
//  Resampling is paced by the shared serial divider: a division per request
//  counts the frame's outputs, then each result takes an index division and
//  one per channel if interpolated (none for a copy), at most two a request.
//  A two-entry queue and the output register let input and output stall apart.
//  Reset is synchronous, active low; it restores defaults and restarts the frame.
// ----------------------------------------------------------------------------
module pcm_downmix_resample_requantize #(
    parameter int MAX_FRAME_SAMPLES = 1152
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pcmdr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pcmdr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  pcmdr_pkg::t_in                        i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output pcmdr_pkg::t_out                       o_out_data
);
    import pcmdr_pkg::*;

    localparam logic [POS_W:0] MAX_LEN = (POS_W+1)'(MAX_FRAME_SAMPLES);

    // Configuration registers
    logic [RATE_W-1:0] r_source_rate, r_output_rate;
    logic              r_mono_out, r_eight_bit_out;
    logic [POS_W-1:0]  r_frame_length;
    logic [POS_W-1:0]  eff_len;
    t_cfg              cfg;

    // Front to queue, queue to back, back to divider
    logic     q_push, q_full, q_pop, q_empty;
    t_qent    q_push_data, q_pop_data;
    t_div_req div_req;
    t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_rate   <= RATE_RESET;
            r_output_rate   <= RATE_RESET;
            r_mono_out      <= 1'b0;
            r_eight_bit_out <= 1'b0;
            r_frame_length  <= FRAME_LEN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SOURCE_RATE:   r_source_rate   <= i_cfg_wdata;
                CFG_OUTPUT_RATE:   r_output_rate   <= i_cfg_wdata;
                CFG_MONO_OUT:      r_mono_out      <= i_cfg_wdata[0];
                CFG_EIGHT_BIT_OUT: r_eight_bit_out <= i_cfg_wdata[0];
                CFG_FRAME_LENGTH:  r_frame_length  <= i_cfg_wdata[POS_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Treat a zero frame length as one, and clamp to MAX_FRAME_SAMPLES
    always_comb begin
        if (r_frame_length == '0) begin
            eff_len = POS_W'(1);
        end else if ({1'b0, r_frame_length} > MAX_LEN) begin
            eff_len = MAX_LEN[POS_W-1:0];
        end else begin
            eff_len = r_frame_length;
        end
        cfg.source_rate   = r_source_rate;
        cfg.output_rate   = r_output_rate;
        cfg.mono_out      = r_mono_out;
        cfg.eight_bit_out = r_eight_bit_out;
        cfg.frame_length  = eff_len;
    end

    // Front: downmix, frame position and previous sample
    pcmdr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (q_push),
        .o_push_data (q_push_data),
        .i_q_full    (q_full)
    );

    // Queue: lets the front take a request while the back is still busy
    pcmdr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty)
    );

    // Back: output schedule, interpolation and requantising into the output register
    pcmdr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .i_q_data    (q_pop_data),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Shared serial divider
    pcmdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

// ----- sim/pcm_downmix_resample_requantize_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_downmix_resample_requantize_test
// Drives sample-pair requests through the downmix / resample / requantise
// block and checks every output sample against a cycle-free predictor or a typed-in value.
// A short scripted part covers the extremes, byte mode, downmix rounding and
// the pass-through cases; random phases then sweep rates, frame lengths and
// channel modes, with bursty requests and a receiver that stalls at will.
// ----------------------------------------------------------------------------
module pcm_downmix_resample_requantize_test;
    import pcmdr_pkg::*;

    localparam int MAX_FRAME       = 1152;
    localparam int RANDOM_REQUESTS = 1900;
    // Idle time after the last output sample: covers requests that yield
    // nothing but are still being scheduled by the serial divider.
    localparam int SETTLE_CYCLES   = 400;

    typedef enum logic [1:0] {
        ROW_WRITE,      // register write, block drained first
        ROW_PREDICTED,  // request checked against the predictor
        ROW_KNOWN       // request with its single output typed in
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    reg_sel;
        logic [15:0] reg_val;
        t_in         req;
        t_out        want;
    } t_script_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_SPARSE,
        STALL_RARE
    } t_stall;

    // Stimulus and block ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;

    // Shadow registers, reset values as the block's
    int unsigned src_rate      = RATE_RESET;
    int unsigned dst_rate      = RATE_RESET;
    bit          mono_mix      = 1'b0;
    bit          byte_mode     = 1'b0;
    int unsigned frame_len_reg = FRAME_LEN_RESET;

    // Resampler state: previous processed pair and frame positions
    int          held_left     = 0;
    int          held_right    = 0;
    int unsigned frame_in_pos  = 0;
    int unsigned frame_out_pos = 0;

    t_out        awaited_outputs [$];
    t_script_row script [$];
    int          burst_left    = 0;
    int          mismatches    = 0;

    pcm_downmix_resample_requantize #(
        .MAX_FRAME_SAMPLES(MAX_FRAME)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // 8-bit mode biases to unsigned and keeps the top byte
    function automatic logic [15:0] requantize(input int s);
        if (byte_mode)
            return 16'((s + 32768) >> 8);
        return 16'(s);
    endfunction

    function automatic t_out shape_output(input int l, input int r, input bit two);
        t_out o;
        o.first_value  = requantize(l);
        o.second_value = two ? requantize(r) : '0;
        o.two_channels = two;
        o.last_of_run  = 1'b0;
        return o;
    endfunction

    // a + (b - a) * frac / dst, product exact, quotient truncated toward zero
    function automatic int lerp(input int a, input int b, input int unsigned frac,
                                input int unsigned dst);
        longint d;
        d = longint'(b - a) * longint'(frac);
        return a + int'(d / longint'(dst));
    endfunction

    // Advance the resampler by one accepted request; queue its outputs when
    // record is set, otherwise only move the state on.
    function automatic void resample_request(input t_in req, input bit record);
        int              left;
        int              right;
        bit              stereo;
        bit              two;
        int unsigned     n;
        int unsigned     p;
        int unsigned     frac;
        longint unsigned outs;
        longint unsigned pos;
        longint unsigned idx;
        int              count;
        t_out            batch [2];

        stereo = req.stereo_in;
        two    = stereo && !mono_mix;
        left   = int'($signed(req.left_sample));
        right  = stereo ? int'($signed(req.right_sample)) : 0;
        if (stereo && mono_mix) begin
            // SV integer division truncates toward zero, as the block does
            left  = (left + right) / 2;
            right = 0;
        end
        // Clamp an out-of-range frame length into 1..max
        n = (frame_len_reg == 0) ? 1 : (frame_len_reg > MAX_FRAME) ? MAX_FRAME
                                                                    : frame_len_reg;
        p     = frame_in_pos;
        count = 0;

        if (dst_rate != 0 && dst_rate < src_rate) begin
            outs = (64'(n) * dst_rate) / src_rate;
            // Emit every scheduled output whose second sample is here,
            // two at most, stale ones from a rate change included
            while (count < 2 && frame_out_pos < outs) begin
                pos  = 64'(frame_out_pos) * src_rate;
                idx  = pos / dst_rate;
                frac = int'(pos % dst_rate);
                if (idx < p)
                    batch[count] = shape_output(lerp(held_left, left, frac, dst_rate),
                                                lerp(held_right, right, frac, dst_rate),
                                                two);
                else if (idx == p && p + 1 >= n)
                    batch[count] = shape_output(left, right, two);
                else
                    break;
                count++;
                frame_out_pos++;
            end
        end else begin
            batch[0] = shape_output(left, right, two);
            count    = 1;
        end

        held_left  = left;
        held_right = right;
        p++;
        // Frame end restarts the phase and drops anything still scheduled
        if (p >= n) begin
            frame_in_pos  = 0;
            frame_out_pos = 0;
        end else begin
            frame_in_pos = p;
        end

        if (count > 0)
            batch[count-1].last_of_run = 1'b1;
        if (record)
            for (int k = 0; k < count; k++)
                awaited_outputs.push_back(batch[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Script and stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void add_write(input t_cfg_idx sel, input logic [15:0] val);
        t_script_row row;
        row.kind    = ROW_WRITE;
        row.reg_sel = sel;
        row.reg_val = val;
        row.req     = '0;
        row.want    = '0;
        script.push_back(row);
    endfunction

    function automatic void add_request(input logic [15:0] l, input logic [15:0] r,
                                        input bit st);
        t_script_row row;
        row.kind    = ROW_PREDICTED;
        row.reg_sel = CFG_SOURCE_RATE;
        row.reg_val = '0;
        row.req     = '{l, r, st};
        row.want    = '0;
        script.push_back(row);
    endfunction

    // Pass-through request: exactly one output, so it is the last of its run
    function automatic void add_known(input logic [15:0] l, input logic [15:0] r,
                                      input bit st, input logic [15:0] f,
                                      input logic [15:0] s, input bit two);
        t_script_row row;
        row.kind    = ROW_KNOWN;
        row.reg_sel = CFG_SOURCE_RATE;
        row.reg_val = '0;
        row.req     = '{l, r, st};
        row.want    = '{f, s, two, 1'b1};
        script.push_back(row);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold one request on the bus until taken. Between bursts, drop valid
    // for a random gap; on a hold, also wait until the block has drained.
    task automatic send_request(input t_in req, input bit steady, input bit hold,
                                input bit record);
        if (hold || (!steady && burst_left == 0)) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            while (hold && awaited_outputs.size() != 0) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        resample_request(req, record);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid, wait for every awaited output, then let the block go idle
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high so that writes can follow back to back
    task automatic write_register(input t_cfg_idx sel, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_idx   <= sel;
        cfg_wdata <= 16'(value);
        @(posedge clk);
        case (sel)
            CFG_SOURCE_RATE:   src_rate      = value & 32'hFFFF;
            CFG_OUTPUT_RATE:   dst_rate      = value & 32'hFFFF;
            CFG_MONO_OUT:      mono_mix      = value[0];
            CFG_EIGHT_BIT_OUT: byte_mode     = value[0];
            CFG_FRAME_LENGTH:  frame_len_reg = value & 32'h7FF;
            default: ;
        endcase
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: stall on a random pattern, drawn anew for each span of cycles
    // ------------------------------------------------------------------------
    initial begin : receiver
        t_stall mode;
        int     span;
        forever begin
            mode = t_stall'($urandom_range(0, 3));
            span = $urandom_range(40, 300);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    STALL_NONE:   out_ready <= 1'b1;
                    STALL_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
                    STALL_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // Compare each accepted output with the oldest awaited one
    always @(posedge clk) begin : output_check
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_outputs.size() == 0) begin
                $error("output with none awaited: %0h", out_data);
                mismatches++;
            end else begin
                want = awaited_outputs.pop_front();
                check_field("first_value", want.first_value, out_data.first_value);
                check_field("second_value", want.second_value, out_data.second_value);
                check_field("two_channels", 16'(want.two_channels),
                            16'(out_data.two_channels));
                check_field("last_of_run", 16'(want.last_of_run),
                            16'(out_data.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    initial begin : driver
        t_in         req;
        int unsigned src;
        int unsigned dst;
        int unsigned len;
        bit          steady;
        bit          writing;
        bit          frame_stereo;
        int          phase_no;
        int          phase_len;
        int          random_sent;

        writing      = 1'b0;
        frame_stereo = 1'b1;
        phase_no     = 0;
        random_sent  = 0;

        // Reset defaults: pass-through, 16-bit, two channels kept
        add_known(16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000, 1'b1);
        add_known(16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF, 1'b1);
        // Mono input: right channel ignored and reported as zero
        add_known(16'hFFFF, 16'h0001, 1'b0, 16'hFFFF, 16'h0000, 1'b0);
        add_known(16'h7FFF, 16'h8000, 1'b0, 16'h7FFF, 16'h0000, 1'b0);
        // Downmix into bytes: averages truncate toward zero, not down
        add_write(CFG_MONO_OUT, 16'd1);
        add_write(CFG_EIGHT_BIT_OUT, 16'd1);
        add_known(16'h7FFF, 16'h8000, 1'b1, 16'h0080, 16'h0000, 1'b0);
        add_known(16'hFFFF, 16'h0000, 1'b1, 16'h0080, 16'h0000, 1'b0);
        add_known(16'h8000, 16'h8000, 1'b1, 16'h0000, 16'h0000, 1'b0);
        add_known(16'h7FFF, 16'h7FFF, 1'b1, 16'h00FF, 16'h0000, 1'b0);
        add_known(16'hFF7F, 16'h1234, 1'b0, 16'h007F, 16'h0000, 1'b0);
        // Output rate of zero means no resampling
        add_write(CFG_EIGHT_BIT_OUT, 16'd0);
        add_write(CFG_MONO_OUT, 16'd0);
        add_write(CFG_OUTPUT_RATE, 16'd0);
        add_known(16'h04D2, 16'hEF1F, 1'b1, 16'h04D2, 16'hEF1F, 1'b1);
        // Output rate above the source rate: pass-through as well
        add_write(CFG_OUTPUT_RATE, 16'd48000);
        add_known(16'hFFFE, 16'h7FFF, 1'b0, 16'hFFFE, 16'h0000, 1'b0);
        // One full frame of five, interpolating between full-scale swings
        add_write(CFG_SOURCE_RATE, 16'd48000);
        add_write(CFG_OUTPUT_RATE, 16'd32000);
        add_write(CFG_FRAME_LENGTH, 16'd5);
        add_request(16'h7FFF, 16'h8000, 1'b1);
        add_request(16'h8000, 16'h7FFF, 1'b1);
        add_request(16'h7FFF, 16'h7FFF, 1'b1);
        add_request(16'h8000, 16'h8000, 1'b1);
        add_request(16'h1234, 16'hEDCC, 1'b1);
        // Sparse schedule, then a rate change mid-frame leaves a backlog
        // that drains two at a time; a shorter frame then drops the rest
        add_write(CFG_OUTPUT_RATE, 16'd8000);
        add_write(CFG_FRAME_LENGTH, 16'd12);
        add_request(16'h0100, 16'hFF00, 1'b1);
        add_request(16'h4000, 16'hC000, 1'b1);
        add_request(16'hC000, 16'h4000, 1'b1);
        add_request(16'h7FFF, 16'h8000, 1'b1);
        add_request(16'h0001, 16'hFFFF, 1'b1);
        add_request(16'h2AAA, 16'hD556, 1'b1);
        add_request(16'h8000, 16'h7FFF, 1'b1);
        add_write(CFG_OUTPUT_RATE, 16'd40000);
        // Channel mode changes within the frame
        add_request(16'h1111, 16'h2222, 1'b0);
        add_write(CFG_FRAME_LENGTH, 16'd9);
        add_request(16'hF0F0, 16'h0F0F, 1'b1);

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == ROW_WRITE) begin
                if (!writing) begin
                    drain_and_settle();
                    writing = 1'b1;
                end
                write_register(script[k].reg_sel, script[k].reg_val);
            end else begin
                if (writing) begin
                    cfg_we  <= 1'b0;
                    writing = 1'b0;
                end
                send_request(script[k].req, 1'b0, 1'b0, script[k].kind == ROW_PREDICTED);
                if (script[k].kind == ROW_KNOWN)
                    awaited_outputs.push_back(script[k].want);
            end
        end

        // Random phases: new settings each time, frames carried across
        while (random_sent < RANDOM_REQUESTS) begin
            src = $urandom_range(8000, 48000);
            dst = $urandom_range(8000, src);
            len = $urandom_range(1, 24);
            case (phase_no % 10)
                0: len = 0;
                1: len = $urandom_range(MAX_FRAME + 1, 2047);
                2: len = MAX_FRAME;
                3: dst = 0;
                4: dst = src;
                5: begin
                    src = 48000;
                    dst = 8000;
                end
                6: begin
                    src = 48000;
                    dst = 47999;
                end
                7: begin
                    src = $urandom_range(1, 65535);
                    dst = $urandom_range(0, 65535);
                end
                default: ;
            endcase

            drain_and_settle();
            write_register(CFG_SOURCE_RATE, src);
            write_register(CFG_OUTPUT_RATE, dst);
            write_register(CFG_MONO_OUT, $urandom_range(0, 1));
            write_register(CFG_EIGHT_BIT_OUT, $urandom_range(0, 1));
            write_register(CFG_FRAME_LENGTH, len);
            cfg_we <= 1'b0;

            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                // Keep the channel mode fixed per frame, bar the odd stray
                if (frame_in_pos == 0)
                    frame_stereo = $urandom_range(0, 1);
                req.left_sample  = pick_sample();
                req.right_sample = pick_sample();
                req.stereo_in    = ($urandom_range(0, 15) == 0) ? !frame_stereo
                                                                 : frame_stereo;
                send_request(req, steady, $urandom_range(0, 63) == 0, 1'b1);
                random_sent++;
            end
            phase_no++;
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Safety net well beyond the slowest correct run
    initial begin : watchdog
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
